// ----- hdl/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// PLL clock frequency calculator package
// Shared widths, constants, state encoding and divider request type.
// ----------------------------------------------------------------------------
package pcf_pkg;

  // Field and datapath widths
  localparam int REF_W   = 26;
  localparam int MULT_W  = 28;  // (int_mult << 18) + frac_mult
  localparam int PROD_W  = 54;  // REF_W + MULT_W
  localparam int DIVR_W  = 6;   // divisors up to 32
  localparam int STEP_W  = 6;   // iteration count up to 54
  localparam int SHIFT_W = 5;   // combined right shift up to 25
  localparam int OUT_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [4:0]        FRAC_SHIFT_MAX = 5'd18;
  localparam logic [REF_W-1:0]  REF_RESET      = REF_W'(25000000);

  // Iteration counts of the two division passes
  localparam logic [STEP_W-1:0] PLL_STEPS = STEP_W'(PROD_W);
  localparam logic [STEP_W-1:0] CLK_STEPS = STEP_W'(OUT_W);

  // Register index of the reference frequency
  localparam logic [0:0] REG_REF_CLK = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV1_GO,
    ST_DIV1,
    ST_DIV2_GO,
    ST_DIV2,
    ST_FINISH
  } pcf_state_t;

  // Start request to the shared divider
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } pcf_div_req_t;

endpackage

// ----- hdl/pcf_div.sv -----
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle for a left-aligned dividend and a
// small divisor; the low bits of the shift register hold the quotient.
// ----------------------------------------------------------------------------
module pcf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  pcf_pkg::pcf_div_req_t           req,
  output logic                            busy,
  output logic                            done,
  output logic [pcf_pkg::OUT_W-1:0]       quotient
);

  logic [pcf_pkg::PROD_W-1:0] q;
  logic [pcf_pkg::DIVR_W-1:0] rem;
  logic [pcf_pkg::DIVR_W-1:0] divisor;
  logic [pcf_pkg::STEP_W-1:0] cnt;
  logic                       active;

  logic [pcf_pkg::DIVR_W:0]   trial;
  logic                       fits;
  logic [pcf_pkg::DIVR_W-1:0] rem_next;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, q[pcf_pkg::PROD_W-1]};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? pcf_pkg::DIVR_W'(trial - {1'b0, divisor})
                    : pcf_pkg::DIVR_W'(trial);
  end

  // Control: load on start, count down the steps, flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= req.steps;
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == pcf_pkg::STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift register for dividend and quotient, plus remainder.
  always_ff @(posedge clk) begin
    if (req.start) begin
      q       <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (active) begin
      q   <= {q[pcf_pkg::PROD_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign busy     = active;
  assign quotient = q[pcf_pkg::OUT_W-1:0];

endmodule

// ----- hdl/pll_clock_frequency_calc.sv -----
// ----------------------------------------------------------------------------
// PLL clock frequency calculator
// Computes the fractional-N PLL output frequency and the derived clock
// frequency from one set of PLL settings and the reference frequency.
// ----------------------------------------------------------------------------
// Each request passes through the multiply step, the PLL quotient pass and then
// the post divider pass, which bypass skips; the shared one-bit-per-cycle divider
// runs 54 steps for the PLL quotient and 32 steps for the post divider.
// Throughput: one request at a time; the next is taken once the previous
// result has moved to the output register.
// Reset: synchronous, active high; ref_clk_hz returns to 25000000.
module pll_clock_frequency_calc (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcf_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [8:0]                        int_mult,
  input  logic [17:0]                       frac_mult,
  input  logic [4:0]                        frac_shift,
  input  logic [4:0]                        ref_div,
  input  logic [2:0]                        out_shift,
  input  logic [4:0]                        post_div,
  input  logic                              bypass,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcf_pkg::OUT_W-1:0]         pll_hz,
  output logic [pcf_pkg::OUT_W-1:0]         clk_hz
);

  pcf_pkg::pcf_state_t state, state_next;

  logic [pcf_pkg::REF_W-1:0]   ref_clk_hz;
  logic                        cfg_write;

  // Latched request
  logic [pcf_pkg::MULT_W-1:0]  mult_r;
  logic [pcf_pkg::SHIFT_W-1:0] shift_r;
  logic [pcf_pkg::DIVR_W-1:0]  rdiv_r;
  logic [pcf_pkg::DIVR_W-1:0]  pdiv_r;
  logic                        bypass_r;

  logic [pcf_pkg::PROD_W-1:0]  prod;
  logic [pcf_pkg::OUT_W-1:0]   pll_r;
  logic [pcf_pkg::OUT_W-1:0]   clk_r;

  // Request decode
  logic                        frac_on;
  logic [4:0]                  fs_sat;
  logic [pcf_pkg::MULT_W-1:0]  mult_in;
  logic [pcf_pkg::SHIFT_W-1:0] shift_in;

  pcf_pkg::pcf_div_req_t       div_req;
  logic                        div_busy;
  logic                        div_done;
  logic [pcf_pkg::OUT_W-1:0]   div_quot;

  logic                        accept;
  logic                        retire;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == pcf_pkg::REG_REF_CLK);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clk_hz <= pcf_pkg::REF_RESET;
    end else if (cfg_write) begin
      ref_clk_hz <= pwdata[pcf_pkg::REF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pcf_pkg::REG_REF_CLK) begin
      prdata = 32'(ref_clk_hz);
    end
  end

  // Feedback multiplier and combined right shift for the incoming request.
  always_comb begin
    frac_on  = (frac_mult != '0);
    fs_sat   = (frac_shift > pcf_pkg::FRAC_SHIFT_MAX) ? pcf_pkg::FRAC_SHIFT_MAX
                                                     : frac_shift;
    mult_in  = frac_on ? ((pcf_pkg::MULT_W'(int_mult) << fs_sat) +
                          pcf_pkg::MULT_W'(frac_mult))
                       : pcf_pkg::MULT_W'(int_mult);
    shift_in = (frac_on ? pcf_pkg::SHIFT_W'(fs_sat) : '0) +
               pcf_pkg::SHIFT_W'(out_shift);
  end

  assign accept = in_valid && in_ready;
  assign retire = (state == pcf_pkg::ST_FINISH) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pcf_pkg::ST_IDLE: begin
        if (in_valid) state_next = pcf_pkg::ST_MUL;
      end
      pcf_pkg::ST_MUL:     state_next = pcf_pkg::ST_DIV1_GO;
      pcf_pkg::ST_DIV1_GO: state_next = pcf_pkg::ST_DIV1;
      pcf_pkg::ST_DIV1: begin
        if (div_done) begin
          state_next = bypass_r ? pcf_pkg::ST_FINISH : pcf_pkg::ST_DIV2_GO;
        end
      end
      pcf_pkg::ST_DIV2_GO: state_next = pcf_pkg::ST_DIV2;
      pcf_pkg::ST_DIV2: begin
        if (div_done) state_next = pcf_pkg::ST_FINISH;
      end
      pcf_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) state_next = pcf_pkg::ST_IDLE;
      end
      default: state_next = pcf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider requests.
  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod >> shift_r;
    div_req.divisor  = rdiv_r;
    div_req.steps    = pcf_pkg::PLL_STEPS;
    case (state)
      pcf_pkg::ST_IDLE: in_ready = 1'b1;
      pcf_pkg::ST_DIV1_GO: div_req.start = 1'b1;
      pcf_pkg::ST_DIV2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {pll_r, {(pcf_pkg::PROD_W - pcf_pkg::OUT_W){1'b0}}};
        div_req.divisor  = pdiv_r;
        div_req.steps    = pcf_pkg::CLK_STEPS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      mult_r   <= mult_in;
      shift_r  <= shift_in;
      rdiv_r   <= (ref_div == '0) ? pcf_pkg::DIVR_W'(1) : pcf_pkg::DIVR_W'(ref_div);
      pdiv_r   <= pcf_pkg::DIVR_W'(post_div) + pcf_pkg::DIVR_W'(1);
      bypass_r <= bypass;
    end
  end

  // Numerator product, then the quotients; bypass sets clk_r to ref_clk_hz.
  always_ff @(posedge clk) begin
    if (state == pcf_pkg::ST_MUL) begin
      prod <= pcf_pkg::PROD_W'(ref_clk_hz) * pcf_pkg::PROD_W'(mult_r);
    end
    if (state == pcf_pkg::ST_DIV1 && div_done) begin
      pll_r <= div_quot;
      if (bypass_r) clk_r <= pcf_pkg::OUT_W'(ref_clk_hz);
    end
    if (state == pcf_pkg::ST_DIV2 && div_done) begin
      clk_r <= div_quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      pll_hz <= pll_r;
      clk_hz <= clk_r;
    end
  end

  pcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // The divider only reports completion to a pass that is waiting for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pcf_pkg::ST_DIV1 || state == pcf_pkg::ST_DIV2))
    else $error("divider finished outside a division pass");

  // A new division never starts on top of one in progress.
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // An accepted request always moves straight to the multiply step.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == pcf_pkg::ST_MUL))
    else $error("accepted request did not enter the multiply step");

endmodule
